[rtl/core/wheel_slip_and_slew_drive_top_defines.svh]
// Assertion helpers for the wheel slip and slew drive.
// Each macro expects clk and rst_n in scope.
`ifndef WHEEL_SLIP_AND_SLEW_DRIVE_TOP_DEFINES_SVH
`define WHEEL_SLIP_AND_SLEW_DRIVE_TOP_DEFINES_SVH

// Same-cycle implication.
`define WSSD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wssd: same-cycle check failed");

// Next-cycle implication.
`define WSSD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wssd: next-cycle check failed");

`endif

[rtl/core/wssd_pkg.sv]
package wssd_pkg;

    localparam int COUNTER_BITS_DEF = 9;
    localparam int WHEELS           = 4;
    localparam int CFG_INDEX_W      = 3;
    localparam int CFG_DATA_W       = 16;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_SLIP_ENABLE       = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CURRENT_THRESHOLD = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_OFF_CYCLES        = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_TRY_CYCLES        = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_ACCEL_STEP        = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_DRIVE_SPEED   = 3'd5;

    typedef logic signed [15:0] speed_t;
    typedef logic [11:0]        current_t;

    typedef struct packed {
        logic        slip_enable;
        logic [11:0] current_threshold;
        logic [7:0]  off_cycles;
        logic [7:0]  try_cycles;
        logic [14:0] accel_step;
        logic [14:0] max_drive_speed;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        slip_enable:       1'b1,
        current_threshold: 12'd640,
        off_cycles:        8'd25,
        try_cycles:        8'd10,
        accel_step:        15'd1638,
        max_drive_speed:   15'd32767
    };

endpackage

[rtl/core/wssd_if.sv]
interface wssd_tick_if;
    import wssd_pkg::*;
    logic     valid;
    logic     ready;
    logic     action;
    speed_t   target_fl;
    speed_t   target_fr;
    speed_t   target_bl;
    speed_t   target_br;
    current_t current_fl;
    current_t current_fr;
    current_t current_bl;
    current_t current_br;

    modport source (
        output valid, action, target_fl, target_fr, target_bl, target_br,
        output current_fl, current_fr, current_bl, current_br,
        input  ready
    );
    modport sink (
        input  valid, action, target_fl, target_fr, target_bl, target_br,
        input  current_fl, current_fr, current_bl, current_br,
        output ready
    );
endinterface

interface wssd_drive_if;
    import wssd_pkg::*;
    logic       valid;
    logic       ready;
    speed_t     drive_fl;
    speed_t     drive_fr;
    speed_t     drive_bl;
    speed_t     drive_br;
    logic [3:0] slip_off_mask;

    modport source (
        output valid, drive_fl, drive_fr, drive_bl, drive_br, slip_off_mask,
        input  ready
    );
    modport sink (
        input  valid, drive_fl, drive_fr, drive_bl, drive_br, slip_off_mask,
        output ready
    );
endinterface

interface wssd_cfg_if;
    import wssd_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[rtl/core/wssd_wheel.sv]
module wssd_wheel #(
    parameter int COUNTER_BITS = wssd_pkg::COUNTER_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  wssd_pkg::cfg_t    cfg,
    input  logic              load,
    input  logic              stop,
    input  wssd_pkg::speed_t  target,
    input  wssd_pkg::current_t current,
    output wssd_pkg::speed_t  held,
    output logic              off
);
    import wssd_pkg::*;

    // compare width: holds the counter and 8-bit magnitudes with sign
    localparam int EW = COUNTER_BITS + 10;
    localparam logic signed [EW-1:0] CNT_HI = EW'((1 <<< (COUNTER_BITS - 1)) - 1);
    localparam logic signed [EW-1:0] CNT_LO = -CNT_HI - EW'(1);

    logic signed [COUNTER_BITS-1:0] counter_reg, counter_next;
    speed_t                         held_reg, held_next;

    logic signed [EW-1:0] cnt_ext, try_ext, off_neg, cnt_inc;
    logic                 active;
    speed_t               tgt_eff;
    logic signed [17:0]   gap, mag, twice, step, sum;

    function automatic logic signed [COUNTER_BITS-1:0] sat_count(
        input logic signed [EW-1:0] v
    );
        logic signed [EW-1:0] r;
        if (v > CNT_HI)
            r = CNT_HI;
        else if (v < CNT_LO)
            r = CNT_LO;
        else
            r = v;
        return COUNTER_BITS'(r);
    endfunction

    function automatic speed_t sat16(input logic signed [17:0] v);
        logic signed [17:0] r;
        if (v > 18'sd32767)
            r = 18'sd32767;
        else if (v < -18'sd32768)
            r = -18'sd32768;
        else
            r = v;
        return speed_t'(r[15:0]);
    endfunction

    // slip phase
    always_comb
    begin
        cnt_ext      = EW'(counter_reg);
        try_ext      = signed'({{(EW-8){1'b0}}, cfg.try_cycles});
        off_neg      = -signed'({{(EW-8){1'b0}}, cfg.off_cycles});
        cnt_inc      = cnt_ext + EW'(1);
        active       = cfg.slip_enable && (target != '0);
        counter_next = counter_reg;
        tgt_eff      = target;
        off          = 1'b0;
        if (active)
        begin
            if (cnt_ext >= try_ext)
            begin
                if (current >= cfg.current_threshold)
                    counter_next = sat_count(off_neg);
            end
            else
            begin
                if (counter_reg < 0)
                begin
                    tgt_eff = '0;
                    off     = !stop;
                end
                counter_next = sat_count(cnt_inc);
            end
        end
    end

    // slew limiter
    always_comb
    begin
        gap   = 18'(tgt_eff) - 18'(held_reg);
        mag   = (gap < 0) ? -gap : gap;
        twice = mag <<< 1;
        step  = signed'({3'b000, cfg.accel_step});
        sum   = '0;
        if (twice < step)
            held_next = tgt_eff;
        else if (tgt_eff > held_reg)
        begin
            sum       = 18'(held_reg) + step;
            held_next = sat16(sum);
        end
        else if (tgt_eff < held_reg)
        begin
            sum       = 18'(held_reg) - step;
            held_next = sat16(sum);
        end
        else
            held_next = held_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_reg <= '0;
            held_reg    <= '0;
        end
        else if (load)
        begin
            if (stop)
                held_reg <= '0;
            else
            begin
                held_reg    <= held_next;
                counter_reg <= counter_next;
            end
        end
    end

    assign held = held_reg;

endmodule

[rtl/core/wssd_scale.sv]
module wssd_scale (
    input  wssd_pkg::speed_t held,
    input  logic [14:0]      max_drive_speed,
    output wssd_pkg::speed_t drive
);
    import wssd_pkg::*;

    logic signed [15:0] mds_s;
    logic signed [31:0] prod;
    logic signed [32:0] rounded;

    // round to nearest, ties up: floor((p + 2^14) / 2^15)
    assign mds_s   = signed'({1'b0, max_drive_speed});
    assign prod    = held * mds_s;
    assign rounded = {prod[31], prod} + 33'sd16384;
    assign drive   = rounded[30:15];

endmodule

[rtl/core/wheel_slip_and_slew_drive_top.sv]
// Four-wheel traction control with slew-rate limiting. Each transfer on tick is one
// control tick: per wheel, a slip counter runs a try phase and, when the motor current
// reaches the threshold, an off phase during which the wheel's target is forced to zero;
// the held speed then moves towards the target by at most accel_step and is scaled by
// max_drive_speed (round to nearest, ties up) onto drive. action = 1 clears all held
// speeds and returns zeros. Three register stages (input, state update, output scaling)
// lie between the transfer of a tick and its drive transfer; a new tick is taken every
// cycle while the receiver keeps drive.ready high. The held speed and slip counter
// registers are updated once per tick, as it leaves stage 1, which is what allows the
// next tick to follow straight away. Configuration writes on cfg are always accepted
// and must only be issued while no tick is in flight.
`include "wheel_slip_and_slew_drive_top_defines.svh"

module wheel_slip_and_slew_drive_top #(
    parameter int COUNTER_BITS = wssd_pkg::COUNTER_BITS_DEF
) (
    input logic         clk,
    input logic         rst_n,
    wssd_cfg_if.sink    cfg,
    wssd_tick_if.sink   tick,
    wssd_drive_if.source drive
);
    import wssd_pkg::*;

    // configuration registers
    cfg_t cfg_reg;

    // stage 1: captured tick
    logic     s1_valid_reg;
    logic     s1_action_reg;
    speed_t   s1_target_reg  [WHEELS];
    current_t s1_current_reg [WHEELS];

    // stage 2: held speeds live in the wheel units, slip mask here
    logic              mid_valid_reg;
    logic [WHEELS-1:0] mask_reg;

    // stage 3: output register
    logic              out_valid_reg;
    speed_t            out_drive_reg [WHEELS];
    logic [WHEELS-1:0] out_mask_reg;

    logic                      out_free, mid_adv, mid_free, s1_adv, s1_free, tick_xfer;
    speed_t [WHEELS-1:0]       held;
    logic   [WHEELS-1:0]       off;
    speed_t                    scaled [WHEELS];

    // handshake chain: each stage moves on when the one after it has room
    assign out_free  = !out_valid_reg || drive.ready;
    assign mid_adv   = mid_valid_reg && out_free;
    assign mid_free  = !mid_valid_reg || mid_adv;
    assign s1_adv    = s1_valid_reg && mid_free;
    assign s1_free   = !s1_valid_reg || s1_adv;
    assign tick_xfer = tick.valid && s1_free;

    assign tick.ready = s1_free;
    assign cfg.ready  = 1'b1;

    // configuration write; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= CFG_RESET;
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_SLIP_ENABLE:       cfg_reg.slip_enable       <= cfg.data[0];
                REG_CURRENT_THRESHOLD: cfg_reg.current_threshold <= cfg.data[11:0];
                REG_OFF_CYCLES:        cfg_reg.off_cycles        <= cfg.data[7:0];
                REG_TRY_CYCLES:        cfg_reg.try_cycles        <= cfg.data[7:0];
                REG_ACCEL_STEP:        cfg_reg.accel_step        <= cfg.data[14:0];
                REG_MAX_DRIVE_SPEED:   cfg_reg.max_drive_speed   <= cfg.data[14:0];
                default:               cfg_reg                   <= cfg_reg;
            endcase
        end
    end

    // stage 1 control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_free)
            s1_valid_reg <= tick.valid;
    end

    // stage 1 payload, wheel order fl, fr, bl, br
    always_ff @(posedge clk)
    begin
        if (tick_xfer)
        begin
            s1_action_reg     <= tick.action;
            s1_target_reg[0]  <= tick.target_fl;
            s1_target_reg[1]  <= tick.target_fr;
            s1_target_reg[2]  <= tick.target_bl;
            s1_target_reg[3]  <= tick.target_br;
            s1_current_reg[0] <= tick.current_fl;
            s1_current_reg[1] <= tick.current_fr;
            s1_current_reg[2] <= tick.current_bl;
            s1_current_reg[3] <= tick.current_br;
        end
    end

    // per-wheel slip and slew, state updated as the tick leaves stage 1
    for (genvar w = 0; w < WHEELS; w++)
    begin : g_wheel
        wssd_wheel #(
            .COUNTER_BITS (COUNTER_BITS)
        ) u_wheel (
            .clk     (clk),
            .rst_n   (rst_n),
            .cfg     (cfg_reg),
            .load    (s1_adv),
            .stop    (s1_action_reg),
            .target  (s1_target_reg[w]),
            .current (s1_current_reg[w]),
            .held    (held[w]),
            .off     (off[w])
        );

        wssd_scale u_scale (
            .held            (held[w]),
            .max_drive_speed (cfg_reg.max_drive_speed),
            .drive           (scaled[w])
        );
    end

    // stage 2 control and mask
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mid_valid_reg <= 1'b0;
        else if (mid_free)
            mid_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
            mask_reg <= off;
    end

    // stage 3: scaled speeds into the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= mid_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (mid_adv)
        begin
            out_drive_reg <= scaled;
            out_mask_reg  <= mask_reg;
        end
    end

    assign drive.valid         = out_valid_reg;
    assign drive.drive_fl      = out_drive_reg[0];
    assign drive.drive_fr      = out_drive_reg[1];
    assign drive.drive_bl      = out_drive_reg[2];
    assign drive.drive_br      = out_drive_reg[3];
    assign drive.slip_off_mask = out_mask_reg;

    // a stop tick leaves every held speed at zero and no wheel flagged
    `WSSD_ASSERT_NEXT(a_stop_clears, s1_adv && s1_action_reg, (held == '0) && (mask_reg == '0))
    // with a zero step the held speeds cannot move on a drive tick
    `WSSD_ASSERT_NEXT(a_zero_step_holds,
                      s1_adv && !s1_action_reg && (cfg_reg.accel_step == '0),
                      held == $past(held))
    // a tick leaving stage 2 always lands in the output register
    `WSSD_ASSERT_NEXT(a_mid_to_out, mid_adv, out_valid_reg)

endmodule

[verif/wssd_drive_checker.sv]
module wssd_drive_checker #(
    parameter int COUNTER_BITS = wssd_pkg::COUNTER_BITS_DEF
) (
    input  logic  clk,
    input  logic  rst_n,
    wssd_cfg_if   cfg,
    wssd_tick_if  tick,
    wssd_drive_if drive,
    output int    mismatches,
    output int    pending_count
);
    import wssd_pkg::*;

    typedef struct {
        speed_t     drive [WHEELS];
        logic [3:0] off_mask;
    } drive_word_t;

    cfg_t                           settings;
    logic signed [COUNTER_BITS-1:0] slip_count [WHEELS];
    speed_t                         held [WHEELS];
    drive_word_t                    expected_drive [$];
    string                          wheel_name [WHEELS] = '{"fl", "fr", "bl", "br"};

    function automatic void note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("wssd check: %s", msg);
        end
    endfunction

    function automatic logic signed [COUNTER_BITS-1:0] clamp_count(input int v);
        int hi = (1 << (COUNTER_BITS - 1)) - 1;
        int lo = -hi - 1;
        if (v > hi)
        begin
            v = hi;
        end
        else if (v < lo)
        begin
            v = lo;
        end
        return v[COUNTER_BITS-1:0];
    endfunction

    function automatic void write_setting(input logic [CFG_INDEX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] value);
        case (idx)
            REG_SLIP_ENABLE:       settings.slip_enable       = value[0];
            REG_CURRENT_THRESHOLD: settings.current_threshold = value[11:0];
            REG_OFF_CYCLES:        settings.off_cycles        = value[7:0];
            REG_TRY_CYCLES:        settings.try_cycles        = value[7:0];
            REG_ACCEL_STEP:        settings.accel_step        = value[14:0];
            REG_MAX_DRIVE_SPEED:   settings.max_drive_speed   = value[14:0];
            default: ;
        endcase
    endfunction

    // one control tick: slip stage, slew stage, output scaling
    function automatic drive_word_t step_wheels(input logic stop,
                                                input speed_t aim_in [WHEELS],
                                                input current_t amps [WHEELS]);
        drive_word_t res;
        int          aim;
        int          now;
        int          gap;
        int          step;
        longint      prod;
        res.off_mask = '0;
        if (stop)
        begin
            for (int w = 0; w < WHEELS; w++)
            begin
                held[w]      = '0;
                res.drive[w] = '0;
            end
            return res;
        end
        step = int'(settings.accel_step);
        for (int w = 0; w < WHEELS; w++)
        begin
            aim = int'(aim_in[w]);
            if (settings.slip_enable && aim != 0)
            begin
                if (int'(slip_count[w]) >= int'(settings.try_cycles))
                begin
                    if (amps[w] >= settings.current_threshold)
                    begin
                        slip_count[w] = clamp_count(-int'(settings.off_cycles));
                    end
                end
                else
                begin
                    if (slip_count[w] < 0)
                    begin
                        aim             = 0;
                        res.off_mask[w] = 1'b1;
                    end
                    slip_count[w] = clamp_count(int'(slip_count[w]) + 1);
                end
            end
            now = int'(held[w]);
            gap = aim - now;
            if (gap < 0)
            begin
                gap = -gap;
            end
            if (2 * gap < step)
            begin
                now = aim;
            end
            else if (aim > now)
            begin
                now = now + step;
            end
            else if (aim < now)
            begin
                now = now - step;
            end
            if (now > 32767)
            begin
                now = 32767;
            end
            else if (now < -32768)
            begin
                now = -32768;
            end
            held[w]      = speed_t'(now);
            // round half up: floor((held * scale + 2^14) / 2^15)
            prod         = longint'(held[w]) * longint'(settings.max_drive_speed) + 64'sd16384;
            res.drive[w] = speed_t'(prod >>> 15);
        end
        return res;
    endfunction

    always @(posedge clk)
    begin
        drive_word_t got;
        drive_word_t want;
        speed_t      aims [WHEELS];
        current_t    amps [WHEELS];
        if (!rst_n)
        begin
            settings   = CFG_RESET;
            mismatches = 0;
            for (int w = 0; w < WHEELS; w++)
            begin
                slip_count[w] = '0;
                held[w]       = '0;
            end
            expected_drive.delete();
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                write_setting(cfg.index, cfg.data);
            end
            if (drive.valid && drive.ready)
            begin
                got.drive[0] = drive.drive_fl;
                got.drive[1] = drive.drive_fr;
                got.drive[2] = drive.drive_bl;
                got.drive[3] = drive.drive_br;
                got.off_mask = drive.slip_off_mask;
                if (expected_drive.size() == 0)
                begin
                    note_mismatch($sformatf("drive transfer with none expected (fl %0d mask %h)",
                                            got.drive[0], got.off_mask));
                end
                else
                begin
                    want = expected_drive.pop_front();
                    for (int w = 0; w < WHEELS; w++)
                    begin
                        if (got.drive[w] !== want.drive[w])
                        begin
                            note_mismatch($sformatf("drive_%s expected %0d got %0d",
                                                    wheel_name[w], want.drive[w], got.drive[w]));
                        end
                    end
                    if (got.off_mask !== want.off_mask)
                    begin
                        note_mismatch($sformatf("slip_off_mask expected %h got %h",
                                                want.off_mask, got.off_mask));
                    end
                end
            end
            if (tick.valid && tick.ready)
            begin
                aims[0] = tick.target_fl;
                aims[1] = tick.target_fr;
                aims[2] = tick.target_bl;
                aims[3] = tick.target_br;
                amps[0] = tick.current_fl;
                amps[1] = tick.current_fr;
                amps[2] = tick.current_bl;
                amps[3] = tick.current_br;
                expected_drive.push_back(step_wheels(tick.action, aims, amps));
            end
        end
        pending_count <= expected_drive.size();
    end

endmodule

[verif/wheel_slip_and_slew_drive_top_tb.sv]
// Testbench top: makes the tick stimulus, the configuration writes and the
// back-pressure on drive, and gives the verdict. All prediction and checking
// lives in wssd_drive_checker, which watches the three channels.
module wheel_slip_and_slew_drive_top_tb;
    import wssd_pkg::*;

    localparam int COUNTER_BITS    = COUNTER_BITS_DEF;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int SETTLE_CYCLES   = 8;
    localparam int LIMIT_CYCLES    = 200000;

    // stimulus phases, each with its own register settings
    localparam int PH_RESET    = 0;  // reset values, written back explicitly
    localparam int PH_FLOOR    = 1;  // every register but slip_enable at its minimum
    localparam int PH_CEILING  = 2;  // every register at its maximum
    localparam int PH_NO_SLIP  = 3;  // slip control off
    localparam int PH_QUIET    = 4;  // no idling on either side
    localparam int PH_HOLD_OFF = 5;  // receiver holds off for a long stretch
    localparam int PH_PAUSE    = 6;  // sender pauses until drained
    localparam int PHASES      = 8;

    localparam speed_t   SPEED_MAX = 16'sh7fff;
    localparam speed_t   SPEED_MIN = 16'sh8000;
    localparam speed_t   SPEED_UP1 = 16'sh0001;
    localparam speed_t   SPEED_DN1 = 16'shffff;
    localparam speed_t   SPEED_NIL = 16'sh0000;
    localparam current_t AMPS_MAX  = 12'hfff;
    localparam current_t AMPS_NIL  = 12'h000;

    logic     clk;
    logic     rst_n;
    int       cycle_count = 0;
    int       mismatches;
    int       pending_count;
    bit       quiet_run    = 1'b0;
    bit       hold_off_req = 1'b0;

    speed_t   next_target [WHEELS];
    current_t next_current [WHEELS];
    speed_t   cruise [WHEELS];   // per-wheel set point, held across ticks
    cfg_t     live_cfg;

    wssd_cfg_if   cfg_ch();
    wssd_tick_if  tick_ch();
    wssd_drive_if drive_ch();

    wheel_slip_and_slew_drive_top #(
        .COUNTER_BITS (COUNTER_BITS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .tick  (tick_ch),
        .drive (drive_ch)
    );

    wssd_drive_checker #(
        .COUNTER_BITS (COUNTER_BITS)
    ) drive_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_ch),
        .tick          (tick_ch),
        .drive         (drive_ch),
        .mismatches    (mismatches),
        .pending_count (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Safety net: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("wheel_slip_and_slew_drive_top: mismatch");
            $finish;
        end
    end

    // Receiver side. Drops ready at random (probability 11 in 100) unless in
    // the quiet stretch; on request it holds ready low for a long, counted
    // stretch so the pipeline fills and tick backs up.
    initial
    begin
        drive_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                drive_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
                drive_ch.ready <= 1'b1;
            end
            else
            begin
                drive_ch.ready <= quiet_run || ($urandom_range(99) >= 11);
            end
        end
    end

    // One register write; upper data bits carry junk, the block must mask it.
    // valid is left high so back-to-back writes need no extra assignment.
    task automatic put_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value, input int width);
        logic [CFG_DATA_W-1:0] junk;
        junk = CFG_DATA_W'($urandom) << width;
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= junk | value;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
    endtask

    task automatic load_settings(input cfg_t s);
        put_reg(REG_SLIP_ENABLE,       CFG_DATA_W'(s.slip_enable),       1);
        put_reg(REG_CURRENT_THRESHOLD, CFG_DATA_W'(s.current_threshold), 12);
        put_reg(REG_OFF_CYCLES,        CFG_DATA_W'(s.off_cycles),        8);
        put_reg(REG_TRY_CYCLES,        CFG_DATA_W'(s.try_cycles),        8);
        put_reg(REG_ACCEL_STEP,        CFG_DATA_W'(s.accel_step),        15);
        put_reg(REG_MAX_DRIVE_SPEED,   CFG_DATA_W'(s.max_drive_speed),   15);
        cfg_ch.valid <= 1'b0;
        live_cfg = s;
    endtask

    // Offer one tick and wait for its transfer. Random gaps go in before
    // valid rises; a back-to-back tick keeps valid high without a dip.
    task automatic offer_tick(input logic act);
        while (!quiet_run && $urandom_range(99) < 11)
        begin
            tick_ch.valid <= 1'b0;
            @(posedge clk);
        end
        tick_ch.valid      <= 1'b1;
        tick_ch.action     <= act;
        tick_ch.target_fl  <= next_target[0];
        tick_ch.target_fr  <= next_target[1];
        tick_ch.target_bl  <= next_target[2];
        tick_ch.target_br  <= next_target[3];
        tick_ch.current_fl <= next_current[0];
        tick_ch.current_fr <= next_current[1];
        tick_ch.current_bl <= next_current[2];
        tick_ch.current_br <= next_current[3];
        @(posedge clk);
        while (!tick_ch.ready) @(posedge clk);
    endtask

    // Stop offering and wait until every expected drive transfer has come.
    // The first edge lets the checker count the last tick just sent.
    task automatic wait_for_drain();
        tick_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
    endtask

    task automatic set_wheels(input speed_t a0, input speed_t a1, input speed_t a2,
                              input speed_t a3, input current_t c0, input current_t c1,
                              input current_t c2, input current_t c3);
        next_target[0]  = a0;
        next_target[1]  = a1;
        next_target[2]  = a2;
        next_target[3]  = a3;
        next_current[0] = c0;
        next_current[1] = c1;
        next_current[2] = c2;
        next_current[3] = c3;
    endtask

    // Rail values, small nonzero speeds of either sign, or anything at all.
    function automatic speed_t pick_speed();
        int     r;
        speed_t v;
        r = $urandom_range(99);
        if (r < 12)
        begin
            v = SPEED_MAX;
        end
        else if (r < 24)
        begin
            v = SPEED_MIN;
        end
        else if (r < 40)
        begin
            v = speed_t'($urandom_range(1, 8));
            if ($urandom_range(1) == 1)
            begin
                v = -v;
            end
        end
        else
        begin
            v = speed_t'($urandom);
        end
        return v;
    endfunction

    // Currents cluster round the threshold so both sides of it are hit often.
    function automatic current_t pick_current(input current_t thr);
        int r;
        r = $urandom_range(99);
        if (r < 10)
        begin
            return AMPS_NIL;
        end
        else if (r < 20)
        begin
            return AMPS_MAX;
        end
        else if (r < 35)
        begin
            return thr;
        end
        else if (r < 45)
        begin
            return thr - 1'b1;
        end
        else if (r < 70)
        begin
            return current_t'($urandom_range(int'(thr)));
        end
        return current_t'($urandom);
    endfunction

    function automatic cfg_t phase_settings(input int p);
        cfg_t s;
        s = CFG_RESET;
        if (p == PH_FLOOR)
        begin
            // zero step: held speeds move only on a stop; zero scale: drive stays 0
            s.slip_enable       = 1'b1;
            s.current_threshold = '0;
            s.off_cycles        = '0;
            s.try_cycles        = '0;
            s.accel_step        = '0;
            s.max_drive_speed   = '0;
        end
        else if (p == PH_CEILING)
        begin
            s.slip_enable       = 1'b1;
            s.current_threshold = '1;
            s.off_cycles        = '1;
            s.try_cycles        = '1;
            s.accel_step        = '1;
            s.max_drive_speed   = '1;
        end
        else if (p != PH_RESET)
        begin
            s.slip_enable       = (p != PH_NO_SLIP);
            s.current_threshold = current_t'($urandom);
            s.off_cycles        = 8'($urandom_range(12));
            s.try_cycles        = 8'($urandom_range(12));
            if ($urandom_range(99) < 35)
            begin
                s.accel_step = 15'($urandom_range(1, 64));
            end
            else
            begin
                s.accel_step = 15'($urandom);
            end
            s.max_drive_speed   = 15'($urandom);
        end
        return s;
    endfunction

    function automatic int phase_len(input int p);
        if (p == PH_RESET)
        begin
            return 100;
        end
        else if (p == PH_FLOOR)
        begin
            return 60;
        end
        else if (p == PH_CEILING)
        begin
            return 300;  // long enough for a 255-tick try phase to run out
        end
        else if (p == PH_NO_SLIP)
        begin
            return 80;
        end
        return 90;
    endfunction

    // Mostly steady drive: each wheel keeps its set point for a while so
    // the try/off phases get exercised, with the odd zero target and stop.
    task automatic roll_tick(output logic act);
        for (int w = 0; w < WHEELS; w++)
        begin
            if ($urandom_range(99) < 8)
            begin
                cruise[w] = pick_speed();
            end
            next_target[w] = cruise[w];
            if ($urandom_range(99) < 8)
            begin
                next_target[w] = SPEED_NIL;
            end
            next_current[w] = pick_current(live_cfg.current_threshold);
        end
        act = ($urandom_range(99) < 4);
    endtask

    initial
    begin
        logic act;
        rst_n              <= 1'b0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.index       <= REG_SLIP_ENABLE;
        cfg_ch.data        <= '0;
        tick_ch.valid      <= 1'b0;
        tick_ch.action     <= 1'b0;
        tick_ch.target_fl  <= SPEED_NIL;
        tick_ch.target_fr  <= SPEED_NIL;
        tick_ch.target_bl  <= SPEED_NIL;
        tick_ch.target_br  <= SPEED_NIL;
        tick_ch.current_fl <= AMPS_NIL;
        tick_ch.current_fr <= AMPS_NIL;
        tick_ch.current_bl <= AMPS_NIL;
        tick_ch.current_br <= AMPS_NIL;
        live_cfg = CFG_RESET;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, on the reset settings (try 10, off 25, threshold 640).
        // Stop with junk on the wheels: everything must come back zero.
        set_wheels(SPEED_MIN, SPEED_MAX, SPEED_DN1, SPEED_UP1,
                   AMPS_MAX, AMPS_MAX, AMPS_NIL, AMPS_NIL);
        offer_tick(1'b1);
        // Rails and +/-1 targets. fl well over threshold and fr exactly on it
        // both slip once the try phase is out; bl one below never does.
        // The last two ticks fall in the off phase for fl and fr.
        set_wheels(SPEED_MAX, SPEED_MIN, SPEED_UP1, SPEED_DN1,
                   AMPS_MAX, 12'd640, 12'd639, AMPS_NIL);
        repeat (13) offer_tick(1'b0);
        // zero targets leave the counters alone
        set_wheels(SPEED_NIL, SPEED_NIL, SPEED_NIL, SPEED_NIL,
                   AMPS_MAX, AMPS_MAX, AMPS_MAX, AMPS_MAX);
        repeat (2) offer_tick(1'b0);
        // stop clears the held speeds but not the slip counters
        offer_tick(1'b1);
        set_wheels(SPEED_MIN, SPEED_MIN, SPEED_MIN, SPEED_MIN,
                   AMPS_MAX, AMPS_MAX, AMPS_MAX, AMPS_MAX);
        repeat (4) offer_tick(1'b0);
        wait_for_drain();

        // Random part, one phase per register setting.
        for (int p = 0; p < PHASES; p++)
        begin
            load_settings(phase_settings(p));
            quiet_run = (p == PH_QUIET);
            for (int w = 0; w < WHEELS; w++)
            begin
                cruise[w] = pick_speed();
            end
            for (int n = 0; n < phase_len(p); n++)
            begin
                if (p == PH_HOLD_OFF && n == 20)
                begin
                    hold_off_req = 1'b1;  // ticks keep coming while drive is held off
                end
                if (p == PH_PAUSE && n == 45)
                begin
                    wait_for_drain();
                end
                roll_tick(act);
                offer_tick(act);
            end
            wait_for_drain();
        end
        quiet_run = 1'b0;
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatches == 0 && pending_count == 0)
        begin
            $display("wheel_slip_and_slew_drive_top: match");
        end
        else
        begin
            $display("wheel_slip_and_slew_drive_top: mismatch");
        end
        $finish;
    end

endmodule
